FILE: rtl/swm_pkg.sv
// shared types and constants for the sliding window minimum block
// no dependencies
package swm_pkg;

	localparam int WINDOW_MAX   = 1024;
	localparam int SAMPLE_WIDTH = 32;
	// positions count modulo twice the window depth
	localparam int POS_W        = $clog2(2 * WINDOW_MAX);
	localparam int LEN_W        = 11;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [POS_W-1:0]               pos_t;
	typedef logic [LEN_W-1:0]               len_t;

	// one candidate as handed between neighbouring cells
	typedef struct packed {
		logic    valid;
		sample_t value;
		pos_t    pos;
	} cand_t;

	// control broadcast to every cell
	typedef struct packed {
		logic    load;
		logic    pop;
		sample_t sample;
		pos_t    pos;
	} cell_ctrl_t;

endpackage

FILE: rtl/swm_cell.sv
// one candidate cell of the minimum chain
// depends on swm_pkg
module swm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  swm_pkg::cell_ctrl_t ctrl,
	input  swm_pkg::cand_t     upper,
	input  logic               prev_keep,
	output swm_pkg::cand_t     cand,
	output logic               keep
);
	import swm_pkg::*;

	logic    valid_q;
	sample_t value_q;
	pos_t    pos_q;
	cand_t   own;
	cand_t   src;

	assign own  = '{valid: valid_q, value: value_q, pos: pos_q};
	assign cand = own;

	// on a pop every cell takes its upper neighbour's contents
	assign src  = ctrl.pop ? upper : own;
	// equal values stay, strictly greater ones are discarded
	assign keep = src.valid && !(src.value > ctrl.sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load) begin
			valid_q <= keep || prev_keep;
		end else if (ctrl.pop) begin
			valid_q <= upper.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			if (keep) begin
				value_q <= src.value;
				pos_q   <= src.pos;
			end else begin
				// first free cell after the survivors takes the new item
				value_q <= ctrl.sample;
				pos_q   <= ctrl.pos;
			end
		end else if (ctrl.pop) begin
			value_q <= upper.value;
			pos_q   <= upper.pos;
		end
	end

endmodule

FILE: rtl/sliding_window_minimum.sv
// top level of the sliding window minimum block: chain of candidate cells
// depends on swm_pkg and swm_cell
//
// usage
// - input channel: sample with in_valid / in_stall, one signed sample per item
// - output channel: window_min with out_valid / out_stall, one result per item
// - cfg_we / cfg_wdata write window_len; zero acts as one, values above the
//   cell count act as the cell count; write only while no item is in flight
// - result appears the cycle after the item is taken, from an output register
// - one item per cycle while the window length is steady and out_stall holds
//   no pending result; after the window is shortened, each further candidate
//   that ages out at once costs an extra single-step shift of the cell chain,
//   with in_stall raised, before the item is taken
// - the oldest candidate sits in cell 0, so the answer is the oldest survivor
// - reset empties the chain, zeroes the position counter and sets the
//   window length to one
// - while out_stall holds a pending result, in_stall is raised and the
//   chain and result register hold still
module sliding_window_minimum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  swm_pkg::sample_t     sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output swm_pkg::sample_t     window_min,
	input  logic                 cfg_we,
	input  swm_pkg::len_t        cfg_wdata
);
	import swm_pkg::*;

	len_t       len_q;
	pos_t       pos_q;
	logic       out_valid_q;
	sample_t    out_q;
	len_t       len_eff;
	pos_t       age0;
	pos_t       age1;
	logic       head_exp;
	logic       next_exp;
	logic       blocked;
	logic       accept;
	logic       pop_only;
	cell_ctrl_t ctrl;
	cand_t      cands [WINDOW_MAX+1];
	logic       keeps [WINDOW_MAX];

	always_comb begin
		if (len_q == '0) begin
			len_eff = len_t'(1);
		end else if (len_q > len_t'(WINDOW_MAX)) begin
			len_eff = len_t'(WINDOW_MAX);
		end else begin
			len_eff = len_q;
		end
	end

	// ages wrap with the position counter
	assign age0     = pos_q - cands[0].pos;
	assign age1     = pos_q - cands[1].pos;
	assign head_exp = cands[0].valid && ({1'b0, age0} >= {1'b0, len_eff});
	assign next_exp = cands[1].valid && ({1'b0, age1} >= {1'b0, len_eff});

	assign blocked  = out_valid_q && out_stall;
	// more than one stale candidate: shift once without taking the item
	assign in_stall = blocked || (head_exp && next_exp);
	assign accept   = in_valid && !in_stall;
	assign pop_only = in_valid && !blocked && head_exp && next_exp;

	assign ctrl.load   = accept;
	assign ctrl.pop    = accept ? head_exp : pop_only;
	assign ctrl.sample = sample;
	assign ctrl.pos    = pos_q;

	assign cands[WINDOW_MAX] = '0;

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
			swm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.upper     (cands[gi+1]),
				.prev_keep ((gi == 0) ? 1'b1 : keeps[(gi == 0) ? 0 : gi-1]),
				.cand      (cands[gi]),
				.keep      (keeps[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= len_t'(1);
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (accept) begin
				pos_q       <= pos_q + pos_t'(1);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// new head: surviving oldest candidate, else the item itself
	always_ff @(posedge clk) begin
		if (accept) begin
			if (keeps[0]) begin
				out_q <= head_exp ? cands[1].value : cands[0].value;
			end else begin
				out_q <= sample;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign window_min = out_q;

endmodule

FILE: dv/tb.sv
// self-checking testbench for sliding_window_minimum: directed table, then random streams
// predicts each window minimum with a candidate queue kept alongside the block
// depends on rtl/swm_pkg.sv and rtl/sliding_window_minimum.sv
`timescale 1ns / 1ps

module tb;
	import swm_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int N_DIRECTED   = 24;
	localparam int CHUNK_ITEMS  = 30;
	localparam int CHUNKS       = 7;
	localparam int FILL_ITEMS   = 576;
	localparam int REPORT_LIMIT = 10;
	localparam int EXPECT_DEPTH = 16;

	typedef struct {
		len_t    wlen;
		sample_t value;
		bit      known;
		sample_t result;
	} step_row_t;

	logic    clk;
	logic    arst_n    = 1'b0;
	logic    in_valid  = 1'b0;
	logic    in_stall;
	sample_t sample_in = '0;
	logic    out_valid;
	logic    out_stall = 1'b0;
	sample_t window_min;
	logic    cfg_we    = 1'b0;
	len_t    cfg_wdata = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;

	// predictor state: candidate ring, oldest at pred_head
	sample_t   pred_value [WINDOW_MAX];
	pos_t      pred_pos   [WINDOW_MAX];
	int        pred_head  = 0;
	int        pred_count = 0;
	pos_t      next_pos = '0;
	len_t      win_len  = 11'd1;

	// expected results still owed by the block
	sample_t   expect_buf [EXPECT_DEPTH];
	int        expect_wr = 0;
	int        expect_rd = 0;

	step_row_t directed_rows [N_DIRECTED] = '{
		'{11'd1,    32'sh7fffffff, 1'b1, 32'sh7fffffff},
		'{11'd1,    32'sh80000000, 1'b1, 32'sh80000000},
		'{11'd1,    32'sh00000000, 1'b1, 32'sh00000000},
		'{11'd0,    5,             1'b1, 5},
		'{11'd0,    -1,            1'b1, -1},
		'{11'd4,    32'sh80000000, 1'b1, 32'sh80000000},
		'{11'd4,    32'sh7fffffff, 1'b1, 32'sh80000000},
		'{11'd4,    3,             1'b0, 0},
		'{11'd4,    3,             1'b0, 0},
		'{11'd4,    9,             1'b0, 0},
		'{11'd4,    2,             1'b0, 0},
		'{11'd4,    2,             1'b0, 0},
		'{11'd2,    8,             1'b0, 0},
		'{11'd2,    1,             1'b0, 0},
		'{11'd2,    6,             1'b0, 0},
		'{11'd2047, -7,            1'b0, 0},
		'{11'd2047, 12,            1'b0, 0},
		'{11'd2047, -7,            1'b0, 0},
		'{11'd2047, 100,           1'b0, 0},
		'{11'd1024, 32'sh7fffffff, 1'b0, 0},
		'{11'd1024, -1,            1'b0, 0},
		'{11'd3,    4,             1'b0, 0},
		'{11'd3,    5,             1'b0, 0},
		'{11'd3,    6,             1'b0, 0}
	};

	sliding_window_minimum uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.window_min (window_min),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// advances the candidate queue by one sample and returns the new minimum
	function automatic sample_t window_min_of(input sample_t s);
		int unsigned span;
		pos_t        age;
		int          slot;
		span = (win_len == 0) ? 1 : ((win_len > WINDOW_MAX) ? WINDOW_MAX : win_len);
		while (pred_count > 0) begin
			age = next_pos - pred_pos[pred_head];
			if (age < span)
				break;
			pred_head = (pred_head + 1) % WINDOW_MAX;
			pred_count--;
		end
		// equal older values are kept
		while (pred_count > 0 &&
			pred_value[(pred_head + pred_count - 1) % WINDOW_MAX] > s)
			pred_count--;
		slot = (pred_head + pred_count) % WINDOW_MAX;
		pred_value[slot] = s;
		pred_pos[slot]   = next_pos;
		pred_count++;
		next_pos++;
		return pred_value[pred_head];
	endfunction

	task automatic send_sample(input sample_t s, input bit known, input sample_t typed);
		sample_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = window_min_of(s);
		expect_buf[expect_wr % EXPECT_DEPTH] = known ? typed : predicted;
		expect_wr++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expect_wr != expect_rd)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window_len(input len_t v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		win_len  = v;
	endtask

	// result side: check accepted items, then decide next stall
	always @(posedge clk) begin : result_check
		sample_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expect_wr == expect_rd) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("window_min %0d arrived with no item outstanding", window_min);
			end else begin
				want = expect_buf[expect_rd % EXPECT_DEPTH];
				expect_rd++;
				if (window_min !== want) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("window_min mismatch: expected %0d, got %0d",
							want, window_min);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		sample_t v;
		len_t    next_len;
		int      mode;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++) begin
			if (directed_rows[r].wlen != win_len) begin
				drain_results();
				write_window_len(directed_rows[r].wlen);
			end
			send_sample(directed_rows[r].value, directed_rows[r].known,
				directed_rows[r].result);
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 78;
				end
				1: begin
					send_idle_pct = 78;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int c = 0; c < CHUNKS; c++) begin
				case ($urandom_range(9))
					0: next_len = 11'd0;
					1: next_len = 11'd1;
					2: next_len = len_t'($urandom_range(1025, 2047));
					3: next_len = 11'd1024;
					4: next_len = len_t'($urandom_range(0, 2047));
					default: next_len = len_t'($urandom_range(2, 24));
				endcase
				drain_results();
				write_window_len(next_len);
				mode = $urandom_range(4);
				v = $urandom;
				for (int i = 0; i < CHUNK_ITEMS; i++) begin
					case (mode)
						0: v = $urandom;
						// narrow range gives many equal values
						1: v = $urandom_range(0, 6) - 3;
						2: v = v + $urandom_range(0, 3);
						3: v = v - $urandom_range(0, 3);
						default: begin
							case ($urandom_range(3))
								0: v = 32'sh80000000;
								1: v = 32'sh7fffffff;
								default: v = $urandom;
							endcase
						end
					endcase
					send_sample(v, 1'b0, '0);
				end
			end
		end

		// long rising run at full depth fills the candidate list deeply
		send_idle_pct = 0;
		recv_idle_pct = 0;
		drain_results();
		write_window_len(11'd1024);
		v = -600;
		for (int i = 0; i < FILL_ITEMS; i++) begin
			v = v + $urandom_range(0, 2);
			send_sample(v, 1'b0, '0);
		end

		// shrink with a long candidate list
		drain_results();
		write_window_len(11'd5);
		for (int i = 0; i < 20; i++)
			send_sample($urandom, 1'b0, '0);

		drain_results();
		if (mismatch_count == 0 && expect_wr == expect_rd)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_minimum.sv
dv/tb.sv
